### design/mvt_pkg.sv
`default_nettype none

package mvt_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  // four products of up to 2^62 each, plus sign
  localparam int ACC_W     = PROD_W + 2;
  localparam int NUM_LANES = 4;
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = REG_IDX_W + 1;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] mvt_word_t;
  typedef logic signed [ACC_W-1:0]  mvt_acc_t;
  typedef mvt_word_t [NUM_LANES-1:0] mvt_vec_t;
  typedef mvt_acc_t  [NUM_LANES-1:0] mvt_accs_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
    logic signed [DATA_W-1:0] in_w;
  } mvt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic [NUM_LANES-1:0]     clip_mask;
  } mvt_out_t;

  // what one cell hands to the next: request valid, the vector, the partial row sums
  typedef struct packed {
    logic      valid;
    mvt_vec_t  vec;
    mvt_accs_t acc;
  } mvt_flow_t;

endpackage

`default_nettype wire

### design/mvt_cell.sv
`default_nettype none

// one matrix column: multiply, then add into the running row sums
module mvt_cell #(
  parameter int COL = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mvt_pkg::mvt_vec_t coef,
  input  wire mvt_pkg::mvt_flow_t up,
  output logic                   up_ready,
  output mvt_pkg::mvt_flow_t     dn,
  input  wire logic              dn_ready
);

  logic                   a_valid;
  mvt_pkg::mvt_vec_t      a_vec;
  mvt_pkg::mvt_accs_t     a_acc;
  logic signed [mvt_pkg::PROD_W-1:0] a_prod [mvt_pkg::NUM_LANES];
  logic signed [mvt_pkg::PROD_W-1:0] prod_next [mvt_pkg::NUM_LANES];

  logic                   b_valid;
  mvt_pkg::mvt_vec_t      b_vec;
  mvt_pkg::mvt_accs_t     b_acc;

  logic a_en;
  logic b_en;

  assign b_en     = ~b_valid | dn_ready;
  assign a_en     = ~a_valid | b_en;
  assign up_ready = a_en;

  always_comb begin
    for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
      prod_next[i] = $signed(coef[i]) * $signed(up.vec[COL]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= up.valid;
      end
      if (b_en) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_vec <= up.vec;
      a_acc <= up.acc;
      for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
        a_prod[i] <= prod_next[i];
      end
    end
    if (b_en) begin
      b_vec <= a_vec;
      for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
        b_acc[i] <= $signed(a_acc[i]) + $signed(a_prod[i]);
      end
    end
  end

  assign dn = '{valid: b_valid, vec: b_vec, acc: b_acc};

endmodule

`default_nettype wire

### design/mvt_sat.sv
`default_nettype none

// fixed-point rescale, saturation and the result register
module mvt_sat #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mvt_pkg::mvt_flow_t up,
  output logic                    up_ready,
  output mvt_pkg::mvt_out_t       res,
  output logic                    res_valid,
  input  wire logic               res_ready
);

  logic signed [mvt_pkg::ACC_W-1:0]  shifted [mvt_pkg::NUM_LANES];
  logic [mvt_pkg::DATA_W-1:0]        lane_val [mvt_pkg::NUM_LANES];
  logic [mvt_pkg::NUM_LANES-1:0]     clip;
  logic [mvt_pkg::ACC_W-mvt_pkg::DATA_W:0] top_bits [mvt_pkg::NUM_LANES];
  logic en;

  assign en       = ~res_valid | res_ready;
  assign up_ready = en;

  always_comb begin
    for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
      // arithmetic shift rounds toward minus infinity
      shifted[i]  = $signed(up.acc[i]) >>> FRAC_BITS;
      top_bits[i] = shifted[i][mvt_pkg::ACC_W-1:mvt_pkg::DATA_W-1];
      clip[i]     = ~((&top_bits[i]) | ~(|top_bits[i]));
      if (clip[i]) begin
        lane_val[i] = shifted[i][mvt_pkg::ACC_W-1] ? mvt_pkg::SAT_MIN : mvt_pkg::SAT_MAX;
      end else begin
        lane_val[i] = shifted[i][mvt_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x     <= lane_val[0];
      res.out_y     <= lane_val[1];
      res.out_z     <= lane_val[2];
      res.out_w     <= lane_val[3];
      res.clip_mask <= clip;
    end
  end

endmodule

`default_nettype wire

### design/matrix_vector_transform_4x4.sv
`default_nettype none

// channel  signals                               payload
// vector   vec_valid / vec_ready / vec            mvt_in_t: in_x, in_y, in_z, in_w
// result   res_valid / res_ready / res            mvt_out_t: out_x..out_w, clip_mask
// config   cfg_valid / cfg_ready / cfg_index,     64-bit coefficient pair, index 0..7
//          cfg_data
//
// one vector request per cycle sustained while res_ready stays high; a request
// passes four column cells of two stages each, then the saturation register
// rst is synchronous: clears every stage valid bit and zeroes the matrix
// each stage moves on when the stage after it is empty or moving, so bubbles
// close up and new requests are taken while a result waits on res_ready
// config is always ready; an index beyond 7 is dropped
module matrix_vector_transform_4x4 #(
  parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          vec_valid,
  output logic                               vec_ready,
  input  wire mvt_pkg::mvt_in_t              vec,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output mvt_pkg::mvt_out_t                  res,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mvt_pkg::REG_W-1:0]     cfg_data
);

  // coefficient registers, packed so the whole set can be compared at once
  logic [mvt_pkg::NUM_REGS-1:0][mvt_pkg::REG_W-1:0] cfg_regs;
  logic cfg_hit;

  // coefficients regrouped by column, one group per cell
  mvt_pkg::mvt_vec_t col_coef [mvt_pkg::NUM_LANES];

  // the chain: flow[0] enters cell 0, flow[NUM_LANES] enters the saturation stage
  mvt_pkg::mvt_flow_t flow [mvt_pkg::NUM_LANES+1];
  logic               rdy  [mvt_pkg::NUM_LANES+1];

  // register write, index range checked
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index < mvt_pkg::CFG_IDX_W'(mvt_pkg::NUM_REGS));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg_hit) begin
      cfg_regs[cfg_index[mvt_pkg::REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // row i, column j sits in register 2i + j/2, odd columns in the upper half
  for (genvar j = 0; j < mvt_pkg::NUM_LANES; j++) begin : g_col
    for (genvar i = 0; i < mvt_pkg::NUM_LANES; i++) begin : g_row
      if (j % 2 == 1) begin : g_hi
        assign col_coef[j][i] = cfg_regs[2*i + j/2][mvt_pkg::REG_W-1:mvt_pkg::DATA_W];
      end else begin : g_lo
        assign col_coef[j][i] = cfg_regs[2*i + j/2][mvt_pkg::DATA_W-1:0];
      end
    end
  end

  // chain head: the vector with empty row sums
  assign flow[0].valid  = vec_valid;
  assign flow[0].vec[0] = vec.in_x;
  assign flow[0].vec[1] = vec.in_y;
  assign flow[0].vec[2] = vec.in_z;
  assign flow[0].vec[3] = vec.in_w;
  assign flow[0].acc    = '0;
  assign vec_ready      = rdy[0];

  for (genvar j = 0; j < mvt_pkg::NUM_LANES; j++) begin : g_cell
    mvt_cell #(
      .COL (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .coef     (col_coef[j]),
      .up       (flow[j]),
      .up_ready (rdy[j]),
      .dn       (flow[j+1]),
      .dn_ready (rdy[j+1])
    );
  end

  mvt_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .up        (flow[mvt_pkg::NUM_LANES]),
    .up_ready  (rdy[mvt_pkg::NUM_LANES]),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

`ifndef SYNTH
  // a flagged component must sit at one of the two rails
  a_clip_x_rail: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.clip_mask[0]) |->
      (res.out_x == mvt_pkg::SAT_MAX || res.out_x == mvt_pkg::SAT_MIN))
    else $error("clip flag on x without a rail value");

  a_clip_w_rail: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.clip_mask[3]) |->
      (res.out_w == mvt_pkg::SAT_MAX || res.out_w == mvt_pkg::SAT_MIN))
    else $error("clip flag on w without a rail value");

  // nothing comes out of the chain straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // an out-of-range index leaves the matrix alone
  a_cfg_drop: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && !cfg_hit) |=> $stable(cfg_regs))
    else $error("matrix changed on an out-of-range write");
`endif

endmodule

`default_nettype wire

### verif/tb_matrix_vector_transform_4x4.sv
`default_nettype none

module tb_matrix_vector_transform_4x4;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W    = mvt_pkg::DATA_W;
  localparam int REG_W     = mvt_pkg::REG_W;
  localparam int NUM_REGS  = mvt_pkg::NUM_REGS;
  localparam int NUM_LANES = mvt_pkg::NUM_LANES;
  localparam int CFG_IDX_W = mvt_pkg::CFG_IDX_W;

  localparam logic [DATA_W-1:0] SAT_MAX = mvt_pkg::SAT_MAX;
  localparam logic [DATA_W-1:0] SAT_MIN = mvt_pkg::SAT_MIN;

  typedef mvt_pkg::mvt_word_t mvt_word_t;
  typedef mvt_pkg::mvt_in_t   mvt_in_t;
  typedef mvt_pkg::mvt_out_t  mvt_out_t;

  // block under test runs at the package default fraction width
  localparam int FRAC        = mvt_pkg::FRAC_BITS_DEF;
  // depth of the pipe from vector request to result, per the block header
  localparam int PIPE_LAT    = 9;
  // wide enough for the exact sum of four 64-bit products plus headroom
  localparam int SUM_W       = 72;
  localparam int LONG_HOLD   = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 100;

  localparam mvt_word_t ONE  = 32'h0001_0000;  // 1.0 in q16.16
  localparam mvt_word_t HALF = 32'h0000_8000;  // 0.5 in q16.16

  localparam logic signed [SUM_W-1:0] WORD_HI = 64'sd2147483647;
  localparam logic signed [SUM_W-1:0] WORD_LO = -64'sd2147483648;

  typedef enum logic [2:0] {
    MAT_ZERO, MAT_IDENT, MAT_HALF, MAT_ALL_MAX, MAT_ALL_MIN, MAT_RANDOM
  } mat_kind_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PULSE, RX_LATE} rx_mode_t;

  // one row of the directed table: the matrix it needs, the vector, and
  // optionally a result typed in by hand
  typedef struct {
    mat_kind_t mat;
    bit        stray;
    mvt_in_t   v;
    bit        typed;
    mvt_out_t  want;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 vec_valid;
  logic                 vec_ready;
  mvt_in_t              vec;
  logic                 res_valid;
  logic                 res_ready;
  mvt_out_t             res;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  // shadow of the coefficient registers, updated on each write that lands in range
  logic [REG_W-1:0] coef_regs [NUM_REGS];
  // transformed vectors still owed by the block, oldest first
  mvt_out_t         transformed_q [$];
  dir_row_t         dir_rows [$];

  string lane_name [NUM_LANES] = '{"out_x", "out_y", "out_z", "out_w"};

  int  errors        = 0;
  int  cycles        = 0;
  int  vecs_sent     = 0;
  int  results_seen  = 0;
  int  clipped_seen  = 0;
  int  cfg_loads     = 0;
  int  long_holds    = 0;
  bit  long_hold_req = 1'b0;

  matrix_vector_transform_4x4 #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .vec_valid (vec_valid),
    .vec_ready (vec_ready),
    .vec       (vec),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mvt_in_t mk_vec(input mvt_word_t x, input mvt_word_t y,
                                     input mvt_word_t z, input mvt_word_t w);
    return '{in_x: x, in_y: y, in_z: z, in_w: w};
  endfunction

  function automatic mvt_out_t mk_res(input mvt_word_t x, input mvt_word_t y,
                                      input mvt_word_t z, input mvt_word_t w,
                                      input logic [NUM_LANES-1:0] mask);
    return '{out_x: x, out_y: y, out_z: z, out_w: w, clip_mask: mask};
  endfunction

  // mix of magnitudes: edge values, full range, around +-2.0, around +-128.0
  function automatic mvt_word_t rand_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return '0;
          3: return '1;
          4: return 32'd1;
          default: return ONE;
        endcase
      end
      1, 2, 3: return r;
      4, 5, 6: return {{14{r[17]}}, r[17:0]};
      default: return {{8{r[23]}}, r[23:0]};
    endcase
  endfunction

  function automatic mvt_in_t rand_vec();
    return mk_vec(rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  function automatic mvt_word_t pick_coef(input mat_kind_t kind, input int row,
                                          input int col);
    case (kind)
      MAT_IDENT:   return (row == col) ? ONE : '0;
      MAT_HALF:    return (row == col) ? HALF : '0;
      MAT_ALL_MAX: return SAT_MAX;
      MAT_ALL_MIN: return SAT_MIN;
      MAT_RANDOM:  return rand_word();
      default:     return '0;
    endcase
  endfunction

  // exact row sums, floor shift, clamp to 32 bits with a flag per lane
  function automatic mvt_out_t transform(input mvt_in_t v);
    mvt_word_t                comp [NUM_LANES];
    mvt_word_t                lane [NUM_LANES];
    logic [NUM_LANES-1:0]     clipped;
    logic [REG_W-1:0]         pair;
    mvt_word_t                c;
    logic signed [SUM_W-1:0]  sum;
    comp[0] = v.in_x;
    comp[1] = v.in_y;
    comp[2] = v.in_z;
    comp[3] = v.in_w;
    clipped = '0;
    for (int row = 0; row < NUM_LANES; row++) begin
      sum = '0;
      for (int col = 0; col < NUM_LANES; col++) begin
        pair = coef_regs[2 * row + col / 2];
        c = (col % 2 == 1) ? pair[REG_W-1:DATA_W] : pair[DATA_W-1:0];
        sum += c * comp[col];
      end
      sum = sum >>> FRAC;
      if (sum > WORD_HI) begin
        lane[row] = SAT_MAX;
        clipped[row] = 1'b1;
      end else if (sum < WORD_LO) begin
        lane[row] = SAT_MIN;
        clipped[row] = 1'b1;
      end else begin
        lane[row] = sum[DATA_W-1:0];
      end
    end
    return mk_res(lane[0], lane[1], lane[2], lane[3], clipped);
  endfunction

  function automatic void add_row(input mat_kind_t mat, input bit stray, input mvt_in_t v,
                                  input bit typed, input mvt_out_t want);
    dir_row_t row;
    row.mat   = mat;
    row.stray = stray;
    row.v     = v;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // one vector request; returns at the edge where it was taken, valid left high
  task automatic send_vec(input mvt_in_t v, input bit typed, input mvt_out_t want);
    vec       <= v;
    vec_valid <= 1'b1;
    @(posedge clk);
    while (!vec_ready) @(posedge clk);
    transformed_q.push_back(typed ? want : transform(v));
    vecs_sent++;
  endtask

  // one register write request; cfg_valid is left high for a following write
  task automatic write_reg(input int idx, input logic [REG_W-1:0] data);
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // indices past the last register are dropped by the block
    if (idx < NUM_REGS) coef_regs[idx] = data;
  endtask

  task automatic load_matrix(input mat_kind_t kind, input bit stray);
    for (int r = 0; r < NUM_REGS; r++) begin
      write_reg(r, {pick_coef(kind, r / 2, 2 * (r % 2) + 1),
                    pick_coef(kind, r / 2, 2 * (r % 2))});
    end
    if (stray) begin
      for (int r = NUM_REGS; r < 2 ** CFG_IDX_W; r++) write_reg(r, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    cfg_loads++;
  endtask

  // stop offering, wait out every owed result, then let the pipe settle
  task automatic drain();
    vec_valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // bursts of random length, and unless no_gaps is set, random gaps with junk on the payload in between
  task automatic run_phase(input int n_items, input bit no_gaps);
    int burst;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_vec(rand_vec(), 1'b0, '0);
        sent++;
      end
      if (!no_gaps) begin
        vec_valid <= 1'b0;
        vec       <= {$urandom, $urandom, $urandom, $urandom};
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
  endtask

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // result side: segments of open, random, pulsed and late ready, plus the
  // long hold-off when the stimulus asks for one
  initial begin : res_side
    int       seg_len;
    int       duty;
    int       period;
    rx_mode_t rx_mode;
    res_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_holds++;
      end else begin
        seg_len = $urandom_range(4, 48);
        duty    = $urandom_range(10, 90);
        period  = $urandom_range(2, 6);
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        for (int c = 0; c < seg_len && !long_hold_req; c++) begin
          case (rx_mode)
            RX_OPEN:   res_ready <= 1'b1;
            RX_RANDOM: res_ready <= ($urandom_range(0, 99) < duty);
            RX_PULSE:  res_ready <= (c % period == 0);
            default:   res_ready <= (c >= seg_len / 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // every accepted result is compared lane by lane with the oldest owed one
  always @(posedge clk) begin : res_check
    mvt_out_t  want;
    mvt_word_t got_l  [NUM_LANES];
    mvt_word_t want_l [NUM_LANES];
    if (!rst && res_valid && res_ready) begin
      if (transformed_q.size() == 0) begin
        $error("result request with no vector outstanding: %h", res);
        errors++;
      end else begin
        want   = transformed_q.pop_front();
        got_l  = '{res.out_x, res.out_y, res.out_z, res.out_w};
        want_l = '{want.out_x, want.out_y, want.out_z, want.out_w};
        for (int i = 0; i < NUM_LANES; i++) begin
          if (got_l[i] !== want_l[i]) begin
            $error("%s: expected %h, got %h", lane_name[i], want_l[i], got_l[i]);
            errors++;
          end
        end
        if (res.clip_mask !== want.clip_mask) begin
          $error("clip_mask: expected %b, got %b", want.clip_mask, res.clip_mask);
          errors++;
        end
        results_seen++;
        if (res.clip_mask != '0) clipped_seen++;
      end
    end
  end

  initial begin : stimulus
    mat_kind_t cur_mat;
    mat_kind_t kind;
    rst       <= 1'b1;
    vec_valid <= 1'b0;
    vec       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int r = 0; r < NUM_REGS; r++) coef_regs[r] = '0;

    // zero matrix straight out of reset: everything collapses to zero
    add_row(MAT_ZERO, 0, mk_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1, mk_res(0, 0, 0, 0, 0));
    add_row(MAT_ZERO, 0, mk_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1, mk_res(0, 0, 0, 0, 0));
    add_row(MAT_ZERO, 0, mk_vec(ONE, -ONE, 0, SAT_MAX), 1, mk_res(0, 0, 0, 0, 0));
    // identity passes every vector through untouched
    add_row(MAT_IDENT, 0, mk_vec(SAT_MAX, SAT_MIN, 0, ONE), 1,
            mk_res(SAT_MAX, SAT_MIN, 0, ONE, 0));
    add_row(MAT_IDENT, 0, mk_vec(-1, 1, 32'h1234_5678, 32'h8765_4321), 1,
            mk_res(-1, 1, 32'h1234_5678, 32'h8765_4321, 0));
    add_row(MAT_IDENT, 0, rand_vec(), 0, '0);
    // half on the diagonal: the shift rounds towards minus infinity
    add_row(MAT_HALF, 0, mk_vec(-1, 1, -3, 3), 1, mk_res(-1, 0, -2, 1, 0));
    add_row(MAT_HALF, 0, mk_vec(SAT_MIN, SAT_MAX, 2, -2), 1,
            mk_res(32'hC000_0000, 32'h3FFF_FFFF, 1, -1, 0));
    // most negative coefficients: the row sum reaches 2^64 without wrapping
    add_row(MAT_ALL_MIN, 0, mk_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1,
            mk_res(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 4'hF));
    add_row(MAT_ALL_MIN, 0, mk_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1,
            mk_res(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 4'hF));
    add_row(MAT_ALL_MIN, 0, mk_vec(0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 0));
    add_row(MAT_ALL_MIN, 0, mk_vec(1, -1, 1, -1), 0, '0);
    add_row(MAT_ALL_MIN, 0, mk_vec(1, 0, 0, 0), 0, '0);
    // most positive coefficients
    add_row(MAT_ALL_MAX, 0, mk_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1,
            mk_res(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 4'hF));
    add_row(MAT_ALL_MAX, 0, mk_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1,
            mk_res(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 4'hF));
    add_row(MAT_ALL_MAX, 0, mk_vec(SAT_MAX, SAT_MIN, 0, 0), 0, '0);
    // identity again, then writes past the last register that must not land
    add_row(MAT_IDENT, 1, mk_vec(32'h0003_8000, 32'hFFFE_0000, 32'h7FFF_0001, 32'h8000_FFFF),
            1, mk_res(32'h0003_8000, 32'hFFFE_0000, 32'h7FFF_0001, 32'h8000_FFFF, 0));
    for (int i = 0; i < 5; i++) add_row(MAT_RANDOM, 0, rand_vec(), 0, '0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table, back to back; the matrix is only reloaded with the pipe empty
    cur_mat = MAT_ZERO;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mat != cur_mat || dir_rows[i].stray) begin
        drain();
        load_matrix(dir_rows[i].mat, dir_rows[i].stray);
        cur_mat = dir_rows[i].mat;
      end
      send_vec(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, each under a fresh matrix; the first five use the fixed matrix kinds
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       kind = MAT_ALL_MAX;
        1:       kind = MAT_ALL_MIN;
        2:       kind = MAT_ZERO;
        3:       kind = MAT_HALF;
        4:       kind = MAT_IDENT;
        default: kind = MAT_RANDOM;
      endcase
      drain();
      load_matrix(kind, $urandom_range(0, 3) == 0);
      // output held off for a long stretch while requests keep coming, so the
      // pipe fills and back-pressure reaches the vector side
      if (p == 6) long_hold_req = 1'b1;
      run_phase(PHASE_ITEMS, p == 6 || p == 10);
    end

    drain();
    $display("covered %0d vector requests under %0d matrix loads, %0d results checked",
             vecs_sent, cfg_loads, results_seen);
    $display("%0d results clipped on some lane, %0d long output hold-offs",
             clipped_seen, long_holds);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### matrix_vector_transform_4x4.f
design/mvt_pkg.sv
design/mvt_cell.sv
design/mvt_sat.sv
design/matrix_vector_transform_4x4.sv
verif/tb_matrix_vector_transform_4x4.sv
